// ===== design/decimal_text_to_integer_with_unit_macros.svh =====
// Assertion macros for the decimal text converter.
// Each macro takes a label, a clock, a disable condition and two expressions.
`ifndef DECIMAL_TEXT_TO_INTEGER_WITH_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_INTEGER_WITH_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define DTIU_ASSERT_IMP(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("dtiu assertion failed");

// Next-cycle implication
`define DTIU_ASSERT_NXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("dtiu assertion failed");

`else

`define DTIU_ASSERT_IMP(label, clk, dis, ante, cons)

`define DTIU_ASSERT_NXT(label, clk, dis, ante, cons)

`endif

`endif

// ===== design/dtiu_pkg.sv =====
`timescale 1ns / 1ps

package dtiu_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int OUT_BITS       = 64;
    localparam int CHAR_BITS      = 8;

    // classified item queue
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CASE_BIT   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_LOW_B   = 8'h62;
    localparam logic [CHAR_BITS-1:0] CH_LOW_G   = 8'h67;
    localparam logic [CHAR_BITS-1:0] CH_LOW_K   = 8'h6B;
    localparam logic [CHAR_BITS-1:0] CH_LOW_M   = 8'h6D;

    // unit scale shifts
    localparam int SHIFT_K = 10;
    localparam int SHIFT_M = 20;
    localparam int SHIFT_G = 30;

    // unit suffix progress
    localparam logic [1:0] UCNT_NONE   = 2'd0;
    localparam logic [1:0] UCNT_LETTER = 2'd1;
    localparam logic [1:0] UCNT_FULL   = 2'd2;

    typedef enum logic [1:0] {
        PH_WS,
        PH_SIGN,
        PH_DIGITS,
        PH_REM
    } t_phase;

    typedef enum logic [1:0] {
        UNIT_NONE,
        UNIT_K,
        UNIT_M,
        UNIT_G
    } t_unit;

    typedef enum logic [2:0] {
        CLS_BLANK,
        CLS_PLUS,
        CLS_MINUS,
        CLS_DIGIT,
        CLS_LETTER,
        CLS_UNIT_B,
        CLS_OTHER,
        CLS_END
    } t_cls;

    // one classified character beat
    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        t_unit      unit;
        logic       size_mode;
    } t_item;

    // control of one finished conversion
    typedef struct packed {
        logic  ok;
        logic  negative;
        t_unit unit;
    } t_fin;

endpackage

// ===== design/dtiu_front.sv =====
`timescale 1ns / 1ps

module dtiu_front (
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [dtiu_pkg::CHAR_BITS-1:0]  i_char_code,
    input  logic                            i_end_mark,
    input  logic                            i_action,
    input  logic                            i_full,
    output logic                            o_push,
    output dtiu_pkg::t_item                 o_item
);
    import dtiu_pkg::*;

    logic [CHAR_BITS-1:0] w_lower;
    logic [CHAR_BITS-1:0] w_offset;
    logic                 w_blank;
    logic                 w_digit;

    // take a beat whenever the queue has room
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // fold upper case letters to lower case
    assign w_lower  = (i_char_code >= CH_UPPER_A && i_char_code <= CH_UPPER_Z) ?
                      (i_char_code | CASE_BIT) : i_char_code;
    assign w_offset = i_char_code - CH_ZERO;
    assign w_blank  = (i_char_code == CH_SPACE) ||
                      (i_char_code >= CH_TAB && i_char_code <= CH_CR);
    assign w_digit  = (i_char_code >= CH_ZERO && i_char_code <= CH_NINE);

    // classify the character
    always_comb begin
        o_item.digit     = w_offset[3:0];
        o_item.size_mode = i_action;
        o_item.unit      = UNIT_NONE;
        o_item.cls       = CLS_OTHER;
        if (i_end_mark) begin
            o_item.cls = CLS_END;
        end else if (w_blank) begin
            o_item.cls = CLS_BLANK;
        end else if (i_char_code == CH_PLUS) begin
            o_item.cls = CLS_PLUS;
        end else if (i_char_code == CH_MINUS) begin
            o_item.cls = CLS_MINUS;
        end else if (w_digit) begin
            o_item.cls = CLS_DIGIT;
        end else if (w_lower == CH_LOW_K) begin
            o_item.cls  = CLS_LETTER;
            o_item.unit = UNIT_K;
        end else if (w_lower == CH_LOW_M) begin
            o_item.cls  = CLS_LETTER;
            o_item.unit = UNIT_M;
        end else if (w_lower == CH_LOW_G) begin
            o_item.cls  = CLS_LETTER;
            o_item.unit = UNIT_G;
        end else if (w_lower == CH_LOW_B) begin
            o_item.cls = CLS_UNIT_B;
        end
    end

endmodule

// ===== design/dtiu_fifo.sv =====
`timescale 1ns / 1ps

module dtiu_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  dtiu_pkg::t_item             i_item,
    output logic                        o_full,
    input  logic                        i_pop,
    output dtiu_pkg::t_item             o_item,
    output logic                        o_empty,
    output logic [dtiu_pkg::CNT_W-1:0]  o_count
);
    import dtiu_pkg::*;

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // advance pointers with wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/dtiu_back.sv =====
`timescale 1ns / 1ps

module dtiu_back #(
    parameter int VALUE_BITS = dtiu_pkg::VALUE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dtiu_pkg::t_item        i_item,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_fin_valid,
    input  logic                   i_fin_ready,
    output dtiu_pkg::t_fin         o_fin,
    output logic [VALUE_BITS-1:0]  o_mag
);
    import dtiu_pkg::*;

    localparam int WB = VALUE_BITS + 4;
    localparam logic [WB-1:0] WIDE_CAP = WB'(1) << (VALUE_BITS - 1);

    t_phase                r_phase;
    t_phase                n_phase;
    logic                  r_negative;
    logic                  n_negative;
    logic [VALUE_BITS-1:0] r_mag;
    logic [VALUE_BITS-1:0] n_mag;
    t_unit                 r_letter;
    t_unit                 n_letter;
    logic [1:0]            r_ucnt;
    logic [1:0]            n_ucnt;
    logic                  r_nonblank;
    logic                  n_nonblank;
    logic                  r_bad;
    logic                  n_bad;

    logic                  w_end;
    logic                  w_is_digit;
    logic                  w_unit_take;
    logic                  w_sign_bad;
    logic [WB-1:0]         w_wide;

    assign w_end       = (i_item.cls == CLS_END);
    assign w_is_digit  = (i_item.cls == CLS_DIGIT);
    assign o_pop       = !i_empty && (!w_end || i_fin_ready);
    assign o_fin_valid = !i_empty && w_end;

    // characters that go to the unit suffix check
    assign w_unit_take = (r_phase == PH_REM) ||
                         (r_phase == PH_DIGITS && !w_is_digit) ||
                         (r_phase == PH_WS && (i_item.cls == CLS_LETTER ||
                                               i_item.cls == CLS_UNIT_B ||
                                               i_item.cls == CLS_OTHER));
    assign w_sign_bad  = (r_phase == PH_SIGN) && !w_is_digit;

    // magnitude times ten plus digit
    assign w_wide = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + WB'(i_item.digit);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (o_pop) begin
            if (w_end) begin
                n_phase = PH_WS;
            end else begin
                case (r_phase)
                    PH_WS: begin
                        if (i_item.cls == CLS_PLUS || i_item.cls == CLS_MINUS) begin
                            n_phase = PH_SIGN;
                        end else if (w_is_digit) begin
                            n_phase = PH_DIGITS;
                        end else if (i_item.cls != CLS_BLANK) begin
                            n_phase = PH_REM;
                        end
                    end
                    PH_SIGN: begin
                        n_phase = w_is_digit ? PH_DIGITS : PH_REM;
                    end
                    PH_DIGITS: begin
                        n_phase = w_is_digit ? PH_DIGITS : PH_REM;
                    end
                    PH_REM: begin
                        n_phase = PH_REM;
                    end
                    default: begin
                        n_phase = PH_WS;
                    end
                endcase
            end
        end
    end

    // data updates and finished record
    always_comb begin
        n_negative = r_negative;
        n_mag      = r_mag;
        n_letter   = r_letter;
        n_ucnt     = r_ucnt;
        n_nonblank = r_nonblank;
        n_bad      = r_bad;

        o_mag          = r_mag;
        o_fin.negative = r_negative;
        o_fin.unit     = (r_phase == PH_DIGITS) ? UNIT_NONE : r_letter;
        o_fin.ok       = r_nonblank && !r_bad && (r_phase != PH_SIGN) &&
                         ((r_phase == PH_DIGITS) ||
                          (i_item.size_mode && r_ucnt == UCNT_FULL));

        if (o_pop) begin
            if (w_end) begin
                // drop all string state
                n_negative = 1'b0;
                n_mag      = '0;
                n_letter   = UNIT_NONE;
                n_ucnt     = UCNT_NONE;
                n_nonblank = 1'b0;
                n_bad      = 1'b0;
            end else begin
                if (r_phase == PH_WS && i_item.cls != CLS_BLANK) begin
                    n_nonblank = 1'b1;
                end
                if (r_phase == PH_WS && i_item.cls == CLS_MINUS) begin
                    n_negative = 1'b1;
                end
                if (w_is_digit && r_phase != PH_REM) begin
                    n_mag = (w_wide > WIDE_CAP) ? WIDE_CAP[VALUE_BITS-1:0]
                                                : w_wide[VALUE_BITS-1:0];
                end
                if (w_sign_bad) begin
                    n_bad = 1'b1;
                end
                if (w_unit_take && !r_bad) begin
                    if (r_ucnt == UCNT_NONE) begin
                        if (i_item.cls == CLS_LETTER) begin
                            n_letter = i_item.unit;
                            n_ucnt   = UCNT_LETTER;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end else if (r_ucnt == UCNT_LETTER && i_item.cls == CLS_UNIT_B) begin
                        n_ucnt = UCNT_FULL;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WS;
            r_negative <= 1'b0;
            r_mag      <= '0;
            r_letter   <= UNIT_NONE;
            r_ucnt     <= UCNT_NONE;
            r_nonblank <= 1'b0;
            r_bad      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_mag      <= n_mag;
            r_letter   <= n_letter;
            r_ucnt     <= n_ucnt;
            r_nonblank <= n_nonblank;
            r_bad      <= n_bad;
        end
    end

endmodule

// ===== design/dtiu_finish.sv =====
`timescale 1ns / 1ps

module dtiu_finish #(
    parameter int VALUE_BITS = dtiu_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fin_valid,
    output logic                                o_fin_ready,
    input  dtiu_pkg::t_fin                      i_fin,
    input  logic [VALUE_BITS-1:0]               i_mag,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [dtiu_pkg::OUT_BITS-1:0] o_value,
    output logic                                o_ok
);
    import dtiu_pkg::*;

    localparam logic [VALUE_BITS-1:0] MAG_CAP = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    logic                        r_valid;
    logic signed [OUT_BITS-1:0]  r_value;
    logic                        r_ok;
    logic signed [OUT_BITS-1:0]  n_value;

    logic [VALUE_BITS-1:0]       w_lim;
    logic [VALUE_BITS-1:0]       w_thr;
    logic [VALUE_BITS-1:0]       w_shifted;
    logic [VALUE_BITS-1:0]       w_scaled;
    logic [VALUE_BITS-1:0]       w_signed;

    assign o_fin_ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_ok        = r_ok;

    // saturation limit depends on sign
    assign w_lim = i_fin.negative ? MAG_CAP : MAG_CAP - 1'b1;

    // pick unit shift and its overflow threshold
    always_comb begin
        case (i_fin.unit)
            UNIT_K: begin
                w_thr     = w_lim >> SHIFT_K;
                w_shifted = i_mag << SHIFT_K;
            end
            UNIT_M: begin
                w_thr     = w_lim >> SHIFT_M;
                w_shifted = i_mag << SHIFT_M;
            end
            UNIT_G: begin
                w_thr     = w_lim >> SHIFT_G;
                w_shifted = i_mag << SHIFT_G;
            end
            default: begin
                w_thr     = w_lim;
                w_shifted = i_mag;
            end
        endcase
    end

    // clamp, apply sign, sign-extend to the output width
    assign w_scaled = (i_mag > w_thr) ? w_lim : w_shifted;
    assign w_signed = i_fin.negative ? ('0 - w_scaled) : w_scaled;
    assign n_value  = i_fin.ok ? OUT_BITS'(signed'(w_signed)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fin_valid && o_fin_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (i_fin_valid && o_fin_ready) begin
            r_value <= n_value;
            r_ok    <= i_fin.ok;
        end
    end

endmodule

// ===== design/decimal_text_to_integer_with_unit.sv =====
// Decimal text to signed integer with optional kb/mb/gb unit.
// Input channel (i_valid/o_ready): one character per beat in i_char_code;
// a beat with i_end_mark high closes the string and its i_action selects
// plain integer (0) or size mode (1). Only the end beat yields a result.
// Output channel (o_valid/i_ready): o_value (signed, saturated to the
// VALUE_BITS limits and sign-extended) and o_ok; o_value is 0 when o_ok is 0.
// Throughput: one character per cycle while no held result stalls the back;
// the front classifies each character into a two-entry queue and the back
// consumes one entry a cycle. The end beat is stored in the queue, and its
// result is registered in the output register when the back pops it.
// Reset: clears the queue, the string state and the output valid flag;
// o_ready is high once the queue has been cleared.
// Stall: a held result keeps the back from consuming the next end beat; the
// queue then fills and o_ready falls, with no beat lost.
`timescale 1ns / 1ps
`include "decimal_text_to_integer_with_unit_macros.svh"

module decimal_text_to_integer_with_unit #(
    parameter int VALUE_BITS = dtiu_pkg::VALUE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [dtiu_pkg::CHAR_BITS-1:0]        i_char_code,
    input  logic                                  i_end_mark,
    input  logic                                  i_action,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [dtiu_pkg::OUT_BITS-1:0]  o_value,
    output logic                                  o_ok
);
    import dtiu_pkg::*;

    t_item                 w_push_item;
    t_item                 w_head_item;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_full;
    logic                  w_empty;
    logic [CNT_W-1:0]      w_count;
    logic                  w_fin_valid;
    logic                  w_fin_ready;
    t_fin                  w_fin;
    logic [VALUE_BITS-1:0] w_mag;

    dtiu_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_end_mark  (i_end_mark),
        .i_action    (i_action),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    dtiu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    dtiu_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_head_item),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_fin_valid (w_fin_valid),
        .i_fin_ready (w_fin_ready),
        .o_fin       (w_fin),
        .o_mag       (w_mag)
    );

    dtiu_finish #(
        .VALUE_BITS (VALUE_BITS)
    ) u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (w_fin_valid),
        .o_fin_ready (w_fin_ready),
        .i_fin       (w_fin),
        .i_mag       (w_mag),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_ok        (o_ok)
    );

    // a rejected string never carries a value
    `DTIU_ASSERT_IMP(a_fail_zero, i_clk, !i_rst_n, o_valid && !o_ok, o_value == '0)
    // queue occupancy stays within its depth
    `DTIU_ASSERT_IMP(a_queue_bound, i_clk, !i_rst_n, 1'b1, w_count <= CNT_W'(QUEUE_DEPTH))
    // reset leaves the block empty and ready
    `DTIU_ASSERT_NXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, !o_valid && o_ready)
    // a pop never happens from an empty queue
    `DTIU_ASSERT_IMP(a_pop_nonempty, i_clk, !i_rst_n, w_pop, !w_empty)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dtiu_pkg::*;

    localparam int          ITEM_TARGET = 1650;
    localparam int          TAIL_BEATS  = 120;
    localparam int          HOLD_AT     = 60;
    localparam int          HOLD_CYCLES = 300;
    localparam int          STUCK_LIMIT = 4000;
    localparam int          DRAIN_WAIT  = 8;
    localparam bit [63:0]   MAG_CAP     = 64'd1 << (VALUE_BITS_DEF - 1);
    localparam bit [63:0]   POS_MAX     = MAG_CAP - 64'd1;

    typedef struct {
        logic [CHAR_BITS-1:0] code;
        logic                 end_mark;
        logic                 action;
    } t_beat;

    typedef struct {
        logic signed [OUT_BITS-1:0] value;
        logic                       ok;
    } t_result;

    // string state of the predictor
    typedef struct {
        t_phase     phase;
        bit         negative;
        bit         nonblank;
        bit         bad;
        bit [63:0]  magnitude;
        t_unit      unit;
        logic [1:0] unit_len;
    } t_conv;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        char_valid  = 1'b0;
    logic                        char_ready;
    logic [CHAR_BITS-1:0]        char_code   = '0;
    logic                        end_mark    = 1'b0;
    logic                        action_sel  = 1'b0;
    logic                        res_valid;
    logic                        res_ready   = 1'b0;
    logic signed [OUT_BITS-1:0]  res_value;
    logic                        res_ok;

    t_beat   text_beats[$];
    t_result pending_results[$];
    t_conv   conv;

    logic    quiet_tail   = 1'b0;
    int      n_errors     = 0;
    int      n_beats_sent = 0;
    int      n_results    = 0;
    int      n_ok         = 0;
    int      n_clamped    = 0;
    int      n_in_stalls  = 0;
    int      stuck_cycles = 0;

    decimal_text_to_integer_with_unit #(
        .VALUE_BITS(VALUE_BITS_DEF)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (char_valid),
        .o_ready     (char_ready),
        .i_char_code (char_code),
        .i_end_mark  (end_mark),
        .i_action    (action_sel),
        .o_valid     (res_valid),
        .i_ready     (res_ready),
        .o_value     (res_value),
        .o_ok        (res_ok)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void restart_conversion();
        conv.phase     = PH_WS;
        conv.negative  = 1'b0;
        conv.nonblank  = 1'b0;
        conv.bad       = 1'b0;
        conv.magnitude = '0;
        conv.unit      = UNIT_NONE;
        conv.unit_len  = UCNT_NONE;
    endfunction

    // accumulate one digit, pin the magnitude at the cap on overflow
    function automatic void add_digit(input logic [CHAR_BITS-1:0] c);
        bit [63:0] d;
        d = 64'(c - CH_ZERO);
        if (conv.magnitude > (MAG_CAP - d) / 64'd10)
            conv.magnitude = MAG_CAP;
        else
            conv.magnitude = conv.magnitude * 64'd10 + d;
    endfunction

    // track the kb/mb/gb suffix; anything else spoils the text
    function automatic void add_unit_char(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] lc;
        lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_BIT) : c;
        if (conv.bad)
            return;
        if (conv.unit_len == UCNT_NONE) begin
            case (lc)
                CH_LOW_K: conv.unit = UNIT_K;
                CH_LOW_M: conv.unit = UNIT_M;
                CH_LOW_G: conv.unit = UNIT_G;
                default: begin
                    conv.bad = 1'b1;
                    return;
                end
            endcase
            conv.unit_len = UCNT_LETTER;
        end else if (conv.unit_len == UCNT_LETTER && lc == CH_LOW_B) begin
            conv.unit_len = UCNT_FULL;
        end else begin
            conv.bad = 1'b1;
        end
    endfunction

    // advance the string state by one beat; on the end beat produce the result
    function automatic bit predict_conversion(input t_beat b, output t_result res);
        logic [CHAR_BITS-1:0] c;
        bit                   is_digit;
        bit [63:0]            m;
        int                   sh;
        c        = b.code;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        res.value = '0;
        res.ok    = 1'b0;
        if (!b.end_mark) begin
            case (conv.phase)
                PH_WS: begin
                    if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                        conv.nonblank = 1'b1;
                        if (c == CH_PLUS || c == CH_MINUS) begin
                            conv.negative = (c == CH_MINUS);
                            conv.phase    = PH_SIGN;
                        end else if (is_digit) begin
                            add_digit(c);
                            conv.phase = PH_DIGITS;
                        end else begin
                            conv.phase = PH_REM;
                            add_unit_char(c);
                        end
                    end
                end
                PH_SIGN: begin
                    if (is_digit) begin
                        add_digit(c);
                        conv.phase = PH_DIGITS;
                    end else begin
                        // text after a bare sign can never be a unit
                        conv.phase = PH_REM;
                        conv.bad   = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        add_digit(c);
                    end else begin
                        conv.phase = PH_REM;
                        add_unit_char(c);
                    end
                end
                default: add_unit_char(c);
            endcase
            return 1'b0;
        end

        m = conv.magnitude;
        if (conv.nonblank && conv.phase != PH_SIGN && !conv.bad) begin
            if (conv.phase == PH_DIGITS) begin
                res.ok = 1'b1;
            end else if (b.action && conv.unit_len == UCNT_FULL) begin
                sh = (conv.unit == UNIT_K) ? SHIFT_K :
                     (conv.unit == UNIT_M) ? SHIFT_M : SHIFT_G;
                res.ok = 1'b1;
                // scale with saturation at the signed limits
                if (conv.negative) begin
                    m = (m > (MAG_CAP >> sh)) ? MAG_CAP : (m << sh);
                end else begin
                    if (m > POS_MAX)
                        m = POS_MAX;
                    m = (m > (POS_MAX >> sh)) ? POS_MAX : (m << sh);
                end
            end
        end
        if (res.ok) begin
            if (conv.negative)
                res.value = 64'd0 - m;
            else
                res.value = (m > POS_MAX) ? POS_MAX : m;
        end
        restart_conversion();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_bytes(input logic [7:0] txt[$], input bit size_mode);
        t_beat b;
        foreach (txt[i]) begin
            b.code     = txt[i];
            b.end_mark = 1'b0;
            b.action   = 1'($urandom_range(0, 1));
            text_beats.push_back(b);
        end
        // close the string; the character on the end beat is don't-care
        b.code     = 8'($urandom_range(0, 255));
        b.end_mark = 1'b1;
        b.action   = size_mode;
        text_beats.push_back(b);
    endtask

    task automatic queue_text(input string s, input bit size_mode);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        queue_bytes(txt, size_mode);
    endtask

    initial begin
        logic [7:0]  txt[$];
        bit          size_mode;
        bit          with_unit;
        int unsigned pick;
        int unsigned n_digits;
        string       bound_txt;

        restart_conversion();

        // directed strings: limits, every mode, each corner of the grammar
        queue_text("", 1'b0);
        queue_text("", 1'b1);
        queue_text(" \t\n\v\f\r", 1'b1);
        queue_text("0", 1'b0);
        queue_text("  -9223372036854775808", 1'b0);
        queue_text("+9223372036854775807", 1'b0);
        queue_text("9223372036854775808", 1'b0);
        queue_text("-99999999999999999999", 1'b1);
        queue_text("+", 1'b1);
        queue_text("-kb", 1'b1);
        queue_text("12kb", 1'b1);
        queue_text("12KB", 1'b0);
        queue_text("kb", 1'b1);
        queue_text("Mb", 1'b0);
        queue_text("k", 1'b1);
        queue_text("12kbx", 1'b1);
        queue_text("12 ", 1'b0);
        queue_text("12bk", 1'b1);
        queue_text("-8GB", 1'b1);
        queue_text("8589934591gb", 1'b1);
        queue_text("8589934592gb", 1'b1);
        queue_text("-8589934592gB", 1'b1);
        queue_text("-9999999999999mb", 1'b1);
        queue_text("\t+7mB", 1'b1);
        txt = '{8'h31, 8'h00};
        queue_bytes(txt, 1'b0);

        // random strings: mostly well formed, some broken, some noise
        while (text_beats.size() < ITEM_TARGET) begin
            txt.delete();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(0, 8))
                    txt.push_back(8'($urandom_range(0, 255)));
                size_mode = 1'($urandom_range(0, 1));
            end else begin
                size_mode = ($urandom_range(0, 2) != 0);
                with_unit = size_mode ? ($urandom_range(0, 1) == 1)
                                      : ($urandom_range(0, 7) == 0);
                // leading blanks
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        pick = $urandom_range(0, 5);
                        txt.push_back((pick == 5) ? CH_SPACE : 8'(CH_TAB + pick));
                    end
                end
                // optional sign
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    txt.push_back(CH_PLUS);
                else if (pick == 1)
                    txt.push_back(CH_MINUS);
                // digits, a few right at the overflow boundaries
                if ($urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       bound_txt = "9223372036854775807";
                        1:       bound_txt = "9223372036854775808";
                        2:       bound_txt = "8589934591";
                        default: bound_txt = "8589934592";
                    endcase
                    for (int i = 0; i < bound_txt.len(); i++)
                        txt.push_back(bound_txt[i]);
                end else begin
                    pick = $urandom_range(0, 9);
                    n_digits = (pick == 0) ? 0 :
                               (pick <= 6) ? pick :
                               (pick <= 8) ? $urandom_range(7, 12) :
                                             $urandom_range(13, 22);
                    repeat (n_digits)
                        txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                // unit suffix in random case
                if (with_unit) begin
                    pick = $urandom_range(0, 2);
                    txt.push_back(((pick == 0) ? CH_LOW_K : (pick == 1) ? CH_LOW_M : CH_LOW_G)
                                  ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00));
                    txt.push_back(CH_LOW_B ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00));
                end
                // break some of them
                if ($urandom_range(0, 5) == 0) begin
                    case ($urandom_range(0, 4))
                        0: txt.insert($urandom_range(0, txt.size()),
                                      8'($urandom_range(0, 255)));
                        1: if (txt.size() > 0) void'(txt.pop_back());
                        2: txt.push_back(CH_SPACE);
                        3: txt.push_back(CH_LOW_B);
                        default: txt.insert($urandom_range(0, txt.size()), CH_MINUS);
                    endcase
                end
            end
            queue_bytes(txt, size_mode);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // let the queue drain, then give the pipeline time to show stray results
        while (text_beats.size() != 0 || char_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        // any prediction still waiting means a result went missing
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived, expected value %0d ok %0b got none",
                     $time, pending_results.size(), pending_results[0].value,
                     pending_results[0].ok);
            n_errors++;
        end

        $display("Summary: %0d strings converted, %0d accepted, %0d rejected, %0d at a limit",
                 n_results, n_ok, n_results - n_ok, n_clamped);
        $display("Summary: %0d character beats sent, input held off %0d cycles",
                 n_beats_sent, n_in_stalls);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Character driver
    // ------------------------------------------------------------------

    int          src_gap  = 0;
    int unsigned src_odds = 0;
    int          n_popped = 0;

    always @(posedge clk) begin
        t_beat   b;
        t_result r;
        if (!rst_n) begin
            char_valid <= 1'b0;
            src_gap = 0;
        end else begin
            // predict on every accepted beat
            if (char_valid && char_ready) begin
                n_beats_sent++;
                b.code     = char_code;
                b.end_mark = end_mark;
                b.action   = action_sel;
                if (predict_conversion(b, r))
                    pending_results.push_back(r);
            end
            if (char_valid && !char_ready)
                n_in_stalls++;

            // hold a beat that is still waiting, otherwise idle or offer the next
            if (!(char_valid && !char_ready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    char_valid <= 1'b0;
                end else if (text_beats.size() == 0) begin
                    char_valid <= 1'b0;
                end else begin
                    b = text_beats.pop_front();
                    char_valid <= 1'b1;
                    char_code  <= b.code;
                    end_mark   <= b.end_mark;
                    action_sel <= b.action;
                    if (n_popped % 64 == 0) begin
                        pick_src_odds : case ($urandom_range(0, 3))
                            0:       src_odds = 0;
                            1:       src_odds = 3;
                            2:       src_odds = 8;
                            default: src_odds = 20;
                        endcase
                    end
                    n_popped++;
                    if (!quiet_tail && src_odds != 0 && $urandom_range(1, src_odds) == 1)
                        src_gap = $urandom_range(1, 17);
                end
            end
            quiet_tail <= (text_beats.size() < TAIL_BEATS);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver
    // ------------------------------------------------------------------

    int          snk_gap   = 0;
    int unsigned snk_odds  = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          snk_cycle = 0;

    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            // compare each result beat with the oldest prediction
            if (res_valid && res_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none predicted, value %0d ok %0b",
                             $time, res_value, res_ok);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    n_results++;
                    if (want.ok)
                        n_ok++;
                    if (want.ok && (want.value == $signed(POS_MAX) ||
                                    want.value == $signed(MAG_CAP)))
                        n_clamped++;
                    if (res_value !== want.value) begin
                        $display("%0t: value mismatch, expected %0d got %0d",
                                 $time, want.value, res_value);
                        n_errors++;
                    end
                    if (res_ok !== want.ok) begin
                        $display("%0t: ok mismatch, expected %0b got %0b",
                                 $time, want.ok, res_ok);
                        n_errors++;
                    end
                end
            end

            if (snk_cycle % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0:       snk_odds = 0;
                    1:       snk_odds = 3;
                    2:       snk_odds = 8;
                    default: snk_odds = 20;
                endcase
            end
            snk_cycle++;

            // random bursts, plus one long back-pressure stretch once HOLD_AT results are in
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
                if (!quiet_tail && snk_odds != 0 && $urandom_range(1, snk_odds) == 1)
                    snk_gap = $urandom_range(1, 17);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when neither channel moves for too long
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n) begin
            if ((char_valid && char_ready) || (res_valid && res_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

endmodule

// ===== decimal_text_to_integer_with_unit.f =====
+incdir+design
design/dtiu_pkg.sv
design/dtiu_front.sv
design/dtiu_fifo.sv
design/dtiu_back.sv
design/dtiu_finish.sv
design/decimal_text_to_integer_with_unit.sv
dv/tb_top.sv
